// ----- hdl/hcva_pkg.sv -----
// Shared widths, codes and store geometry for the hex cell volume accumulator.
package hcva_pkg;

    localparam int CELLS  = 4096;
    localparam int ADDR_W = $clog2(CELLS);

    localparam int CRD_W  = 24;
    localparam int CB_W   = 13;
    localparam int SUM_W  = CRD_W + 2;
    localparam int DIF_W  = CRD_W + 1;
    localparam int MOP_W  = SUM_W;
    localparam int PRD_W  = 2 * MOP_W;
    localparam int CRS_W  = 2 * DIF_W + 1;
    localparam int CLO_W  = CRS_W - MOP_W;
    localparam int ACC_W  = 79;
    localparam int FRC_SH = 19;
    localparam int QUO_W  = ACC_W - FRC_SH;
    localparam int DIG_W  = 20;
    localparam int DIG_N  = QUO_W / DIG_W;
    localparam int DIV_SH = 24;
    localparam int CNT_W  = $clog2(DIG_N);
    localparam int AMT_W  = 64;

    localparam logic [ACC_W-1:0]  ROUND_BIAS = ACC_W'(3 * (1 << 18));
    localparam logic [DIV_SH-2:0] DIV3_MUL   = 23'd5592406;

    localparam logic CMD_CORNER = 1'b0;
    localparam logic CMD_READ   = 1'b1;
    localparam logic KIND_FACE  = 1'b0;
    localparam logic KIND_VOL   = 1'b1;

    localparam logic [1:0] LAST_CORNER = 2'd3;

endpackage

// ----- hdl/hex_cell_volume_accumulator.sv -----
// Hex cell volume accumulator: face corners in, face contributions and cell volumes out.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------------
//  input    | in        | i_valid / o_stall | i_cmd i_cell_a i_cell_b i_corner i_px/y/z
//  result   | out       | o_valid / i_stall | o_kind o_cell_res o_amount
//
//  Corner items 0..2 leave o_stall low. A read passes through ST_RDV and ST_DONE. A face corner 3
//  runs 12 products through one 26x26 multiplier, then a divide by three in three 20-bit digits
//  by reciprocal multiply on the same multiplier, then two read-modify-writes of the store, the
//  second skipped when there is no right cell (i_cell_b negative).
//  After reset the 4096-entry volume store is cleared, one entry a cycle; o_stall is high
//  meanwhile. A result held by i_stall holds the block only when the next result is ready.
module hex_cell_volume_accumulator
    import hcva_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_cmd,
    input  logic [ADDR_W-1:0]       i_cell_a,
    input  logic signed [CB_W-1:0]  i_cell_b,
    input  logic [1:0]              i_corner,
    input  logic signed [CRD_W-1:0] i_px,
    input  logic signed [CRD_W-1:0] i_py,
    input  logic signed [CRD_W-1:0] i_pz,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic                    o_kind,
    output logic [ADDR_W-1:0]       o_cell_res,
    output logic signed [AMT_W-1:0] o_amount
);

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_MUL, ST_ACC, ST_PREP, ST_DIV, ST_DSUB, ST_FIN,
        ST_WRA, ST_RDB, ST_WRB, ST_RDV, ST_DONE
    } t_state;

    t_state n_state;
    t_state r_state;

    logic [ADDR_W-1:0]       r_clr;
    logic signed [CRD_W-1:0] r_cx [3];
    logic signed [CRD_W-1:0] r_cy [3];
    logic signed [CRD_W-1:0] r_cz [3];
    logic signed [SUM_W-1:0] r_s  [3];
    logic signed [DIF_W-1:0] r_da [3];
    logic signed [DIF_W-1:0] r_db [3];
    logic signed [CRS_W-1:0] r_c  [3];
    logic signed [PRD_W-1:0] r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic [QUO_W-1:0]        r_dvd;
    logic [1:0]              r_rem;
    logic                    r_neg;
    logic [CNT_W-1:0]        r_cnt;
    logic [3:0]              r_step;
    logic [ADDR_W-1:0]       r_ca;
    logic signed [CB_W-1:0]  r_cb;
    logic                    r_kind;
    logic signed [AMT_W-1:0] r_dv;
    logic signed [AMT_W-1:0] r_rd;
    logic                    r_o_valid;
    logic                    r_o_kind;
    logic [ADDR_W-1:0]       r_o_cell;
    logic signed [AMT_W-1:0] r_o_amt;

    logic [AMT_W-1:0]        mem [CELLS];
    logic                    mem_we;
    logic [ADDR_W-1:0]       mem_wa;
    logic [AMT_W-1:0]        mem_wd;
    logic [ADDR_W-1:0]       mem_ra;

    logic                    accept;
    logic signed [MOP_W-1:0] m_a;
    logic signed [MOP_W-1:0] m_b;
    logic signed [PRD_W-1:0] m_p;
    logic [DIG_W+1:0]        d_x;
    logic [DIG_W-1:0]        d_q;
    logic [DIG_W+1:0]        d_r;
    logic [QUO_W-1:0]        q_fix;
    logic [1:0]              c_idx;

    function automatic logic signed [AMT_W-1:0] sat_sum(
        input logic signed [AMT_W-1:0] a,
        input logic signed [AMT_W-1:0] b,
        input logic                    sub
    );
        logic signed [AMT_W:0] s;
        logic signed [AMT_W-1:0] r;
        s = sub ? ((AMT_W+1)'(a) - (AMT_W+1)'(b)) : ((AMT_W+1)'(a) + (AMT_W+1)'(b));
        if (s[AMT_W] != s[AMT_W-1]) begin
            r = s[AMT_W] ? {1'b1, {(AMT_W-1){1'b0}}} : {1'b0, {(AMT_W-1){1'b1}}};
        end else begin
            r = s[AMT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [MOP_W-1:0] c_hi(input logic signed [CRS_W-1:0] c);
        return $signed(c[CRS_W-1:CLO_W]);
    endfunction

    function automatic logic signed [MOP_W-1:0] c_lo(input logic signed [CRS_W-1:0] c);
        return $signed({{(MOP_W-CLO_W){1'b0}}, c[CLO_W-1:0]});
    endfunction

    assign o_stall    = (r_state != ST_IDLE);
    assign accept     = i_valid && !o_stall;
    assign o_valid    = r_o_valid;
    assign o_kind     = r_o_kind;
    assign o_cell_res = r_o_cell;
    assign o_amount   = r_o_amt;

    always_comb begin
        d_x = {r_rem, r_dvd[QUO_W-1 -: DIG_W]};
        case (r_step)
            4'd0:    begin m_a = MOP_W'(r_da[2]); m_b = MOP_W'(r_db[1]); end
            4'd1:    begin m_a = MOP_W'(r_da[1]); m_b = MOP_W'(r_db[2]); end
            4'd2:    begin m_a = MOP_W'(r_da[0]); m_b = MOP_W'(r_db[2]); end
            4'd3:    begin m_a = MOP_W'(r_da[2]); m_b = MOP_W'(r_db[0]); end
            4'd4:    begin m_a = MOP_W'(r_da[1]); m_b = MOP_W'(r_db[0]); end
            4'd5:    begin m_a = MOP_W'(r_da[0]); m_b = MOP_W'(r_db[1]); end
            4'd6:    begin m_a = r_s[0]; m_b = c_hi(r_c[0]); end
            4'd7:    begin m_a = r_s[0]; m_b = c_lo(r_c[0]); end
            4'd8:    begin m_a = r_s[1]; m_b = c_hi(r_c[1]); end
            4'd9:    begin m_a = r_s[1]; m_b = c_lo(r_c[1]); end
            4'd10:   begin m_a = r_s[2]; m_b = c_hi(r_c[2]); end
            4'd11:   begin m_a = r_s[2]; m_b = c_lo(r_c[2]); end
            4'd12:   begin m_a = MOP_W'(d_x); m_b = MOP_W'(DIV3_MUL); end
            default: begin m_a = '0; m_b = '0; end
        endcase
        m_p   = m_a * m_b;
        c_idx = r_step[2:1];
        d_q   = r_prod[DIV_SH +: DIG_W];
        d_r   = d_x - ({1'b0, d_q, 1'b0} + {2'b00, d_q});
        q_fix = r_neg ? ~r_dvd : r_dvd;
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_ca;
        mem_wd = '0;
        mem_ra = r_ca;
        unique case (r_state)
            ST_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
            end
            ST_IDLE: mem_ra = i_cell_a;
            ST_WRA: begin
                mem_we = 1'b1;
                mem_wd = sat_sum(r_rd, r_dv, 1'b0);
            end
            ST_RDB: mem_ra = r_cb[ADDR_W-1:0];
            ST_WRB: begin
                mem_we = 1'b1;
                mem_wa = r_cb[ADDR_W-1:0];
                mem_wd = sat_sum(r_rd, r_dv, 1'b1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[mem_ra];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:  if (r_clr == ADDR_W'(CELLS - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept && i_cmd == CMD_READ) begin
                    n_state = ST_RDV;
                end else if (accept && i_corner == LAST_CORNER) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_ACC;
            ST_ACC:  n_state = (r_step == 4'd11) ? ST_PREP : ST_MUL;
            ST_PREP: n_state = ST_DIV;
            ST_DIV:  n_state = ST_DSUB;
            ST_DSUB: n_state = (r_cnt == CNT_W'(DIG_N - 1)) ? ST_FIN : ST_DIV;
            ST_FIN:  n_state = ST_WRA;
            ST_WRA:  n_state = r_cb[CB_W-1] ? ST_DONE : ST_RDB;
            ST_RDB:  n_state = ST_WRB;
            ST_WRB:  n_state = ST_DONE;
            ST_RDV:  n_state = ST_DONE;
            ST_DONE: if (!r_o_valid || !i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_cx[k] <= '0;
                r_cy[k] <= '0;
                r_cz[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && (!r_o_valid || !i_stall)) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && !i_stall) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLR: r_clr <= r_clr + 1'b1;
                ST_IDLE: begin
                    if (accept) begin
                        r_ca   <= i_cell_a;
                        r_cb   <= i_cell_b;
                        r_kind <= i_cmd;
                        r_step <= '0;
                        r_acc  <= ROUND_BIAS;
                        if (i_cmd == CMD_CORNER && i_corner != LAST_CORNER) begin
                            r_cx[i_corner] <= i_px;
                            r_cy[i_corner] <= i_py;
                            r_cz[i_corner] <= i_pz;
                        end
                        r_s[0]  <= SUM_W'(r_cx[0]) + SUM_W'(r_cx[1])
                                 + SUM_W'(r_cx[2]) + SUM_W'(i_px);
                        r_s[1]  <= SUM_W'(r_cy[0]) + SUM_W'(r_cy[1])
                                 + SUM_W'(r_cy[2]) + SUM_W'(i_py);
                        r_s[2]  <= SUM_W'(r_cz[0]) + SUM_W'(r_cz[1])
                                 + SUM_W'(r_cz[2]) + SUM_W'(i_pz);
                        r_da[0] <= DIF_W'(r_cx[2]) - DIF_W'(r_cx[0]);
                        r_da[1] <= DIF_W'(r_cy[2]) - DIF_W'(r_cy[0]);
                        r_da[2] <= DIF_W'(r_cz[2]) - DIF_W'(r_cz[0]);
                        r_db[0] <= DIF_W'(r_cx[1]) - DIF_W'(i_px);
                        r_db[1] <= DIF_W'(r_cy[1]) - DIF_W'(i_py);
                        r_db[2] <= DIF_W'(r_cz[1]) - DIF_W'(i_pz);
                    end
                end
                ST_MUL: r_prod <= m_p;
                ST_ACC: begin
                    r_step <= r_step + 1'b1;
                    if (r_step < 4'd6) begin
                        if (!r_step[0]) begin
                            r_c[c_idx] <= r_prod[CRS_W-1:0];
                        end else begin
                            r_c[c_idx] <= r_c[c_idx] - r_prod[CRS_W-1:0];
                        end
                    end else if (!r_step[0]) begin
                        r_acc <= r_acc + (ACC_W'(r_prod) <<< CLO_W);
                    end else begin
                        r_acc <= r_acc + ACC_W'(r_prod);
                    end
                end
                ST_PREP: begin
                    r_neg <= r_acc[ACC_W-1];
                    r_dvd <= r_acc[ACC_W-1] ? ~r_acc[ACC_W-1:FRC_SH] : r_acc[ACC_W-1:FRC_SH];
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                ST_DIV: r_prod <= m_p;
                ST_DSUB: begin
                    r_cnt <= r_cnt + 1'b1;
                    r_rem <= d_r[1:0];
                    r_dvd <= {r_dvd[QUO_W-DIG_W-1:0], d_q};
                end
                ST_FIN: r_dv <= AMT_W'($signed(q_fix));
                ST_RDV: r_dv <= r_rd;
                ST_DONE: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_kind  <= (r_kind == CMD_READ) ? KIND_VOL : KIND_FACE;
                        r_o_cell  <= r_ca;
                        r_o_amt   <= r_dv;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule
